>>> rtl/core/qte_pkg.sv
// Shared widths, constants and the lookup function for the quaternion to Euler angle core.
package qte_pkg;

    localparam int W_QUAT = 16;
    localparam int W_PROD = 32;
    localparam int W_SUM  = 34;
    localparam int W_S31  = 31;
    localparam int W_SQ   = 62;
    localparam int W_CRD  = 38;
    localparam int W_ACC  = 28;
    localparam int W_Q6   = 19;
    localparam int N_SQRT = 31;
    localparam int N_CRD  = 20;
    localparam int N_CH   = 3;
    localparam int LAT    = 3 + N_SQRT + 1 + N_CRD + 2;

    localparam int CH_ASIN = 0;
    localparam int CH_Z    = 1;
    localparam int CH_X    = 2;

    typedef logic signed [W_CRD-1:0] t_crd;
    typedef logic signed [W_ACC-1:0] t_acc;
    typedef logic signed [W_Q6-1:0]  t_q6;

    localparam logic signed [W_SUM-1:0] ONE_Q30 = W_SUM'(64'sd1073741824);
    localparam t_acc ACC180  = W_ACC'(32'sd11796480);
    localparam t_q6  DEG90   = W_Q6'(32'sd5760);
    localparam t_q6  DEG180  = W_Q6'(32'sd11520);
    localparam t_q6  DEG360  = W_Q6'(32'sd23040);

    typedef struct packed {
        t_crd x;
        t_crd y;
        t_acc acc;
    } t_crd_st;

    // atan(2^-i) in degrees scaled by 2^16.
    function automatic t_acc atan_lut(input logic [4:0] i);
        t_acc r;
        unique case (i)
            5'd0:    r = W_ACC'(32'sd2949120);
            5'd1:    r = W_ACC'(32'sd1740967);
            5'd2:    r = W_ACC'(32'sd919879);
            5'd3:    r = W_ACC'(32'sd466945);
            5'd4:    r = W_ACC'(32'sd234379);
            5'd5:    r = W_ACC'(32'sd117304);
            5'd6:    r = W_ACC'(32'sd58666);
            5'd7:    r = W_ACC'(32'sd29335);
            5'd8:    r = W_ACC'(32'sd14668);
            5'd9:    r = W_ACC'(32'sd7334);
            5'd10:   r = W_ACC'(32'sd3667);
            5'd11:   r = W_ACC'(32'sd1833);
            5'd12:   r = W_ACC'(32'sd917);
            5'd13:   r = W_ACC'(32'sd458);
            5'd14:   r = W_ACC'(32'sd229);
            5'd15:   r = W_ACC'(32'sd115);
            5'd16:   r = W_ACC'(32'sd57);
            5'd17:   r = W_ACC'(32'sd29);
            5'd18:   r = W_ACC'(32'sd14);
            5'd19:   r = W_ACC'(32'sd7);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/qte_in_if.sv
// Input channel interface carrying one quaternion item.
interface qte_in_if;
    import qte_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [W_QUAT-1:0] quat_w;
    logic signed [W_QUAT-1:0] quat_x;
    logic signed [W_QUAT-1:0] quat_y;
    logic signed [W_QUAT-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> rtl/core/qte_out_if.sv
// Output channel interface carrying one Euler angle item.
interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               pole_clamped;
    modport source (output valid, angle_x, angle_y, angle_z, pole_clamped, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, pole_clamped, output ready);
endinterface

>>> rtl/core/quaternion_to_euler_degrees_core.sv
// Top level of the quaternion to Euler angle core in Q10.6 degrees.
// Throughput is one item per cycle while not stalled; the whole pipeline advances together.
// The pipeline stalls only when the output register holds an item not yet taken.
// Reset is synchronous and active low; it clears all valid bits, not the data.
// Stages: products, sums, square, 31 root cells, CORDIC setup, 20 cells, round, fold.
module quaternion_to_euler_degrees_core
    import qte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    qte_in_if.sink     i_quat,
    qte_out_if.source  o_euler
);
    typedef struct packed {
        logic                     pole;
        logic                     s_neg;
        logic signed [W_S31-1:0]  s;
        logic signed [W_SUM-1:0]  zy;
        logic signed [W_SUM-1:0]  zx;
        logic signed [W_SUM-1:0]  xy;
        logic signed [W_SUM-1:0]  xx;
    } t_side_a;

    typedef struct packed {
        logic              pole;
        logic              s_neg;
        logic [N_CH-1:0]   zero;
    } t_side_b;

    // The single enable moves every stage at once.
    logic w_en;
    logic r_vld [LAT];

    assign w_en         = !r_vld[LAT-1] || o_euler.ready;
    assign i_quat.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_quat.valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage one: the nine component products, each exact at scale 2^30.
    logic signed [W_PROD-1:0] r_wy, r_zx, r_wz, r_xy, r_yy, r_zz, r_wx, r_yz, r_xx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wy <= W_PROD'(i_quat.quat_w) * W_PROD'(i_quat.quat_y);
            r_zx <= W_PROD'(i_quat.quat_z) * W_PROD'(i_quat.quat_x);
            r_wz <= W_PROD'(i_quat.quat_w) * W_PROD'(i_quat.quat_z);
            r_xy <= W_PROD'(i_quat.quat_x) * W_PROD'(i_quat.quat_y);
            r_yy <= W_PROD'(i_quat.quat_y) * W_PROD'(i_quat.quat_y);
            r_zz <= W_PROD'(i_quat.quat_z) * W_PROD'(i_quat.quat_z);
            r_wx <= W_PROD'(i_quat.quat_w) * W_PROD'(i_quat.quat_x);
            r_yz <= W_PROD'(i_quat.quat_y) * W_PROD'(i_quat.quat_z);
            r_xx <= W_PROD'(i_quat.quat_x) * W_PROD'(i_quat.quat_x);
        end
    end

    // Stage two: the sine argument of the middle angle and the two atan2 operand pairs.
    logic signed [W_SUM-1:0] w_s, r2_s, r2_zy, r2_zx, r2_xy, r2_xx;
    logic                    r2_pole;

    assign w_s = (W_SUM'(r_wy) - W_SUM'(r_zx)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_s    <= w_s;
            r2_pole <= (w_s >= ONE_Q30) || (w_s <= -ONE_Q30);
            r2_zy   <= (W_SUM'(r_wz) + W_SUM'(r_xy)) <<< 1;
            r2_zx   <= ONE_Q30 - ((W_SUM'(r_yy) + W_SUM'(r_zz)) <<< 1);
            r2_xy   <= (W_SUM'(r_wx) + W_SUM'(r_yz)) <<< 1;
            r2_xx   <= ONE_Q30 - ((W_SUM'(r_xx) + W_SUM'(r_yy)) <<< 1);
        end
    end

    // Stage three: square of the argument. Off the pole it fits in 31 bits.
    logic signed [W_S31-1:0] w_s31;
    logic signed [W_SQ-1:0]  r3_sq;
    t_side_a                 r_sa [N_SQRT+1];

    assign w_s31 = r2_s[W_S31-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sq         <= W_SQ'(w_s31) * W_SQ'(w_s31);
            r_sa[0].pole  <= r2_pole;
            r_sa[0].s_neg <= r2_s[W_SUM-1];
            r_sa[0].s     <= w_s31;
            r_sa[0].zy    <= r2_zy;
            r_sa[0].zx    <= r2_zx;
            r_sa[0].xy    <= r2_xy;
            r_sa[0].xx    <= r2_xx;
            for (int k = 0; k < N_SQRT; k++) r_sa[k+1] <= r_sa[k];
        end
    end

    // Cosine of the middle angle: square root of 2^60 minus the square, one digit a cell.
    logic [W_SQ-1:0] w_v [N_SQRT+1];
    logic [W_SQ-1:0] w_r [N_SQRT+1];

    assign w_v[0] = (W_SQ'(1) << 60) - W_SQ'(r3_sq);
    assign w_r[0] = '0;

    for (genvar g = 0; g < N_SQRT; g++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_pos (6'(60 - 2 * g)),
            .i_v   (w_v[g]),
            .i_res (w_r[g]),
            .o_v   (w_v[g+1]),
            .o_res (w_r[g+1])
        );
    end

    // CORDIC setup: a zero vector is flagged, and a negative x is turned over by 180 degrees.
    t_crd    w_py [N_CH];
    t_crd    w_px [N_CH];
    t_crd_st n_pre [N_CH];
    t_crd_st r_pre [N_CH];
    t_crd_st w_crd [N_CH][N_CRD+1];
    logic [N_CH-1:0] w_zero;
    t_side_b r_sb [N_CRD+1];

    always_comb begin
        w_py[CH_ASIN] = W_CRD'(r_sa[N_SQRT].s);
        w_px[CH_ASIN] = W_CRD'(w_r[N_SQRT][W_S31-1:0]);
        w_py[CH_Z]    = W_CRD'(r_sa[N_SQRT].zy);
        w_px[CH_Z]    = W_CRD'(r_sa[N_SQRT].zx);
        w_py[CH_X]    = W_CRD'(r_sa[N_SQRT].xy);
        w_px[CH_X]    = W_CRD'(r_sa[N_SQRT].xx);
        for (int c = 0; c < N_CH; c++) begin
            w_zero[c] = (w_px[c] == '0) && (w_py[c] == '0);
            if (w_px[c][W_CRD-1]) begin
                n_pre[c].x   = -w_px[c];
                n_pre[c].y   = -w_py[c];
                n_pre[c].acc = w_py[c][W_CRD-1] ? -ACC180 : ACC180;
            end else begin
                n_pre[c].x   = w_px[c];
                n_pre[c].y   = w_py[c];
                n_pre[c].acc = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < N_CH; c++) r_pre[c] <= n_pre[c];
            r_sb[0].pole  <= r_sa[N_SQRT].pole;
            r_sb[0].s_neg <= r_sa[N_SQRT].s_neg;
            r_sb[0].zero  <= w_zero;
            for (int k = 0; k < N_CRD; k++) r_sb[k+1] <= r_sb[k];
        end
    end

    // Three CORDIC chains side by side: middle, third and first angle.
    for (genvar c = 0; c < N_CH; c++) begin : g_ch
        assign w_crd[c][0] = r_pre[c];
        for (genvar g = 0; g < N_CRD; g++) begin : g_cell
            qte_cordic_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_step (5'(g)),
                .i_d    (w_crd[c][g]),
                .o_d    (w_crd[c][g+1])
            );
        end
    end

    // Rounding to Q10.6 with saturation.
    function automatic t_q6 to_q6(input t_acc a, input t_q6 lim);
        logic signed [W_ACC:0] t;
        t_q6                   r;
        t = (W_ACC+1)'(a) + (W_ACC+1)'(512);
        r = W_Q6'(t >>> 10);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    t_acc w_acc [N_CH];
    t_q6  r_ay, r_az, r_ax;
    logic r_pole;

    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            w_acc[c] = r_sb[N_CRD].zero[c] ? '0 : w_crd[c][N_CRD].acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pole <= r_sb[N_CRD].pole;
            if (r_sb[N_CRD].pole) begin
                r_ay <= r_sb[N_CRD].s_neg ? -DEG90 : DEG90;
            end else begin
                r_ay <= to_q6(w_acc[CH_ASIN], DEG90);
            end
            r_az <= to_q6(w_acc[CH_Z], DEG180);
            r_ax <= to_q6(w_acc[CH_X], DEG180);
        end
    end

    // Final stage: fold the first angle into the right half plane, then the wrap of the middle.
    t_q6 f_ax, f_ay, f_az;
    logic signed [13:0] r_oax;
    logic signed [15:0] r_oay, r_oaz;
    logic               r_opole;

    always_comb begin
        f_ax = r_ax;
        f_ay = r_ay;
        f_az = r_az;
        if (f_ax < -DEG90) begin
            f_ax = f_ax + DEG180;
            f_az = f_az + DEG180;
            f_ay = DEG180 - f_ay;
        end
        if (f_ax > DEG90) begin
            f_ax = f_ax - DEG180;
            f_az = f_az - DEG180;
            f_ay = DEG180 - f_ay;
        end
        if (f_ay > DEG360) begin
            f_ay = f_ay - DEG360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oax   <= f_ax[13:0];
            r_oay   <= f_ay[15:0];
            r_oaz   <= f_az[15:0];
            r_opole <= r_pole;
        end
    end

    assign o_euler.valid        = r_vld[LAT-1];
    assign o_euler.angle_x      = r_oax;
    assign o_euler.angle_y      = r_oay;
    assign o_euler.angle_z      = r_oaz;
    assign o_euler.pole_clamped = r_opole;
endmodule

>>> rtl/core/qte_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module qte_sqrt_cell
    import qte_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [5:0]      i_pos,
    input  logic [W_SQ-1:0] i_v,
    input  logic [W_SQ-1:0] i_res,
    output logic [W_SQ-1:0] o_v,
    output logic [W_SQ-1:0] o_res
);
    logic [W_SQ-1:0] w_bit, w_sum, n_v, n_res, r_v, r_res;

    always_comb begin
        w_bit = W_SQ'(1) << i_pos;
        w_sum = i_res + w_bit;
        if (i_v >= w_sum) begin
            n_v   = i_v - w_sum;
            n_res = (i_res >> 1) + w_bit;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_res <= n_res;
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;
endmodule

>>> rtl/core/qte_cordic_cell.sv
// One vectoring-mode CORDIC rotation cell.
module qte_cordic_cell
    import qte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_crd_st    i_d,
    output t_crd_st    o_d
);
    t_crd    w_dx, w_dy;
    t_acc    w_ang;
    t_crd_st n_d, r_d;

    always_comb begin
        w_dx  = i_d.y >>> i_step;
        w_dy  = i_d.x >>> i_step;
        w_ang = atan_lut(i_step);
        if (!i_d.y[W_CRD-1]) begin
            n_d.x   = i_d.x + w_dx;
            n_d.y   = i_d.y - w_dy;
            n_d.acc = i_d.acc + w_ang;
        end else begin
            n_d.x   = i_d.x - w_dx;
            n_d.y   = i_d.y + w_dy;
            n_d.acc = i_d.acc - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

>>> rtl/core/qte_checker.sv
// Port-level checker for the quaternion to Euler angle core, bound to the top level.
module qte_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [13:0] i_angle_x,
    input logic signed [15:0] i_angle_y,
    input logic signed [15:0] i_angle_z,
    input logic               i_pole
);
    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result item shown right after reset");

    // A waiting result item holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_angle_x)
        && $stable(i_angle_y) && $stable(i_angle_z) && $stable(i_pole))
        else $error("stalled result item changed");

    // With no result waiting the core must take input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A clamped pole puts the middle angle at plus or minus 90 degrees, or at 270 after the fold.
    a_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pole |-> (i_angle_y == 16'sd5760) || (i_angle_y == -16'sd5760)
        || (i_angle_y == 16'sd17280))
        else $error("pole item with wrong middle angle");

    // After folding the first angle lies within plus or minus 90 degrees.
    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle_x >= -14'sd5760) && (i_angle_x <= 14'sd5760))
        else $error("first angle outside the folded range");
endmodule

bind quaternion_to_euler_degrees_core qte_checker u_qte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_quat.ready),
    .i_out_valid (o_euler.valid),
    .i_out_ready (o_euler.ready),
    .i_angle_x   (o_euler.angle_x),
    .i_angle_y   (o_euler.angle_y),
    .i_angle_z   (o_euler.angle_z),
    .i_pole      (o_euler.pole_clamped)
);

>>> tb/quaternion_to_euler_degrees_core_test.sv
// Testbench for the quaternion to Euler angle core: random and directed quaternions checked
// against a behavioral predictor of the CORDIC arithmetic.
`timescale 1ns / 1ps

module quaternion_to_euler_degrees_core_test;
    import qte_pkg::*;

    // Q10.6 constants for the fold and clamp logic.
    localparam longint Q6_DEG90  = 5760;
    localparam longint Q6_DEG180 = 11520;
    localparam longint Q6_DEG360 = 23040;
    localparam longint UNIT_Q30  = 64'sd1 << 30;
    localparam int     STALL_LIMIT = 4000;

    // One predicted result item.
    typedef struct {
        logic signed [13:0] ang_x;
        logic signed [15:0] ang_y;
        logic signed [15:0] ang_z;
        logic               pole;
    } t_euler;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qte_in_if  quat_ch ();
    qte_out_if euler_ch ();

    quaternion_to_euler_degrees_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_euler (euler_ch.source)
    );

    always #6 i_clk = ~i_clk;

    t_euler pending_angles[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     timed_out = 1'b0;

    // Table of atan(2^-i) in degrees scaled by 2^16.
    longint atan_steps [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                                29, 14, 7};

    // Arithmetic shift right that rounds toward minus infinity.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Truncated integer square root by bit-pair search.
    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return longint'(root);
    endfunction

    // Vectoring CORDIC; the angle comes back in degrees scaled by 2^16.
    function automatic longint cordic_atan2(longint yv, longint xv);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        // The left half plane starts from +-180 after a rotation by half a turn.
        if (xv < 0) begin
            acc = (yv >= 0) ? 180 * 65536 : -180 * 65536;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < 20; i++) begin
            dx = floor_shift(yv, i);
            dy = floor_shift(xv, i);
            if (yv >= 0) begin
                xv += dx;
                yv -= dy;
                acc += atan_steps[i];
            end else begin
                xv -= dx;
                yv += dy;
                acc -= atan_steps[i];
            end
        end
        return acc;
    endfunction

    // Round the 2^16 degree accumulator to Q10.6 and saturate it.
    function automatic longint round_to_q6(longint a, longint lim);
        longint r;
        r = floor_shift(a + 512, 10);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_euler predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz);
        t_euler res;
        longint w;
        longint x;
        longint y;
        longint z;
        longint s;
        longint ax;
        longint ay;
        longint az;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        res.pole = 1'b0;
        s = 2 * (w * y - z * x);
        // The pole test is exact on the Q30 argument.
        if (s >= UNIT_Q30) begin
            ay = Q6_DEG90;
            res.pole = 1'b1;
        end else if (s <= -UNIT_Q30) begin
            ay = -Q6_DEG90;
            res.pole = 1'b1;
        end else begin
            ay = round_to_q6(cordic_atan2(s, int_sqrt((64'd1 << 60) - longint'(s * s))),
                             Q6_DEG90);
        end
        az = round_to_q6(cordic_atan2(2 * (w * z + x * y), UNIT_Q30 - 2 * (y * y + z * z)),
                         Q6_DEG180);
        ax = round_to_q6(cordic_atan2(2 * (w * x + y * z), UNIT_Q30 - 2 * (x * x + y * y)),
                         Q6_DEG180);
        // Fold the roll angle into +-90; exactly +-90 stays where it is.
        if (ax < -Q6_DEG90) begin
            ax += Q6_DEG180;
            az += Q6_DEG180;
            ay = Q6_DEG180 - ay;
        end
        if (ax > Q6_DEG90) begin
            ax -= Q6_DEG180;
            az -= Q6_DEG180;
            ay = Q6_DEG180 - ay;
        end
        if (ay > Q6_DEG360) ay -= Q6_DEG360;
        res.ang_x = ax[13:0];
        res.ang_y = ay[15:0];
        res.ang_z = az[15:0];
        return res;
    endfunction

    // Drive one quaternion and hold it until the core accepts it. Valid stays high after
    // the handshake so that the next item can follow without a gap.
    task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz);
        while ($urandom_range(99) < send_idle_pct) begin
            quat_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        quat_ch.valid <= 1'b1;
        quat_ch.quat_w <= qw;
        quat_ch.quat_x <= qx;
        quat_ch.quat_y <= qy;
        quat_ch.quat_z <= qz;
        do @(posedge i_clk); while (!quat_ch.ready);
        pending_angles.insert(pending_angles.size(), predict_angles(qw, qx, qy, qz));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        quat_ch.valid <= 1'b0;
        while (pending_angles.size() != 0 && !timed_out) @(negedge i_clk);
    endtask

    // Random quaternion: in six draws out of ten each component lies in -16384..16383, so the
    // norm is at most one; the other draws use the full 16-bit range of every component.
    task automatic send_random_quat();
        int mode;
        logic signed [15:0] q [4];
        mode = $urandom_range(9);
        for (int k = 0; k < 4; k++) begin
            if (mode < 6) q[k] = 16'($signed($urandom_range(32767)) - 16384);
            else q[k] = 16'($urandom);
        end
        send_quat(q[0], q[1], q[2], q[3]);
    endtask

    task automatic test_directed();
        logic signed [15:0] maxp;
        logic signed [15:0] minn;
        maxp = 16'sh7FFF;
        minn = 16'sh8000;
        send_quat(0, 0, 0, 0);                  // all-zero quaternion
        send_quat(maxp, 0, 0, 0);               // identity
        send_quat(minn, 0, 0, 0);
        send_quat(0, maxp, 0, 0);               // roll of 180: negative x axis
        send_quat(0, 0, maxp, 0);
        send_quat(0, 0, 0, maxp);
        send_quat(0, minn, 0, 0);
        send_quat(23170, 0, 23170, 0);          // just short of the pole, positive
        send_quat(23170, 0, -23170, 0);         // just short of the pole, negative
        send_quat(16384, 16384, 16384, -16384); // pole through the z x term
        send_quat(23170, 23170, 0, 0);          // roll of exactly 90: no fold
        send_quat(23170, -23170, 0, 0);
        send_quat(16384, 23170, 0, 0);          // unnormalised, roll just under 90
        send_quat(16384, -23170, 5000, 3000);
        send_quat(maxp, maxp, maxp, maxp);
        send_quat(minn, minn, minn, minn);
        send_quat(maxp, minn, maxp, minn);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 1, 1, 1);
        drain_results();
    endtask

    task automatic test_random_phase(int n, int snd, int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        repeat (n) send_random_quat();
        drain_results();
    endtask

    // Sender holds off until the core has emptied, then resumes in a burst.
    task automatic test_pause_until_empty();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (40) send_random_quat();
        drain_results();
        repeat (80) send_random_quat();
        drain_results();
    endtask

    // Receiver: ready toggles at random; results are checked on the rising edge.
    always @(negedge i_clk) begin
        euler_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && euler_ch.valid && euler_ch.ready) begin
            t_euler exp_a;
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
            end else begin
                exp_a = pending_angles.pop_front();
                if (euler_ch.angle_x !== exp_a.ang_x || euler_ch.angle_y !== exp_a.ang_y ||
                    euler_ch.angle_z !== exp_a.ang_z ||
                    euler_ch.pole_clamped !== exp_a.pole) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp x=%0d y=%0d z=%0d p=%0b got x=%0d y=%0d z=%0d p=%0b",
                                 exp_a.ang_x, exp_a.ang_y, exp_a.ang_z, exp_a.pole,
                                 euler_ch.angle_x, euler_ch.angle_y, euler_ch.angle_z,
                                 euler_ch.pole_clamped);
                end
            end
        end
    end

    // Watchdog: counts cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        quat_ch.valid = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        euler_ch.ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(150, 0, 0);
        test_random_phase(100, 75, 0);
        test_random_phase(100, 0, 75);
        test_random_phase(100, 35, 35);
        test_pause_until_empty();
        repeat (100) @(negedge i_clk);
        if (mismatches == 0 && pending_angles.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
